@@ src/kqt_pkg.sv @@
`default_nettype none

package kqt_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int QTY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OSLOT_W  = 6;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic signed [QTY_W-1:0] QTY_MAX = {1'b0, {(QTY_W-1){1'b1}}};
    localparam logic signed [QTY_W-1:0] QTY_MIN = {1'b1, {(QTY_W-1){1'b0}}};

    typedef struct packed {
        logic                     active;
        logic [ACTION_W-1:0]      action;
        logic [KEY_W-1:0]         part_key;
        logic signed [QTY_W-1:0]  amount;
        logic [STATUS_W-1:0]      status;
        logic signed [QTY_W-1:0]  quantity;
        logic [SLOT_W-1:0]        slot;
    } kqt_token_t;

endpackage

`default_nettype wire

@@ src/kqt_if.sv @@
`default_nettype none

interface kqt_req_if
    import kqt_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic [ACTION_W-1:0]     action;
    logic signed [KEY_W-1:0] part_key;
    logic signed [QTY_W-1:0] amount;

    modport source (output valid, output action, output part_key, output amount,
                    input ready);
    modport sink   (input valid, input action, input part_key, input amount,
                    output ready);
endinterface

interface kqt_rsp_if
    import kqt_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [QTY_W-1:0] quantity;
    logic [OSLOT_W-1:0]      slot;

    modport source (output valid, output status, output quantity, output slot,
                    input ready);
    modport sink   (input valid, input status, input quantity, input slot,
                    output ready);
endinterface

`default_nettype wire

@@ src/keyed_quantity_table.sv @@
`default_nettype none

// Key and signed quantity table of CAPACITY entries held in a row of cells,
// one entry per cell. A request travels down the row one cell per clock
// unless a waiting result word holds the row; each cell checks its own
// entry and inserts, reads or updates it in place. A request moves from the
// head register through the cell registers into the output register, and
// the table works on one request at a time: req.ready is high whenever no
// request is in the row, also while a result word still waits in the output
// register. A full table rejects an insert before any key is compared.

module keyed_quantity_table
    import kqt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    kqt_req_if.sink    req,
    kqt_rsp_if.source  rsp
);

    kqt_token_t              chain [CAPACITY+1];
    kqt_token_t              head_reg;
    kqt_token_t              head_next;
    kqt_token_t              tail;
    logic                    busy_reg;
    logic [CNT_W-1:0]        fill_reg;
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic signed [QTY_W-1:0] out_qty_reg;
    logic [OSLOT_W-1:0]      out_slot_reg;
    logic                    adv;
    logic                    take;

    assign tail      = chain[CAPACITY];
    assign adv       = !(tail.active && out_valid_reg && !rsp.ready);
    assign take      = req.valid && req.ready;
    assign req.ready = !busy_reg;
    assign chain[0]  = head_reg;

    always_comb
    begin
        head_next          = '0;
        head_next.active   = take;
        head_next.action   = req.action;
        head_next.part_key = req.part_key;
        head_next.amount   = req.amount;
        head_next.quantity = '0;
        head_next.slot     = '0;
        if (req.action == ACT_INSERT && fill_reg == CNT_W'(CAPACITY))
        begin
            head_next.status = ST_FULL;
        end
        else
        begin
            head_next.status = ST_NOT_FOUND;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        kqt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .idx     (SLOT_W'(g)),
            .fill    (fill_reg),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            busy_reg      <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                head_reg <= head_next;
            end
            if (take)
            begin
                busy_reg <= 1'b1;
            end
            if (adv && tail.active)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                if (tail.action == ACT_INSERT && tail.status == ST_DONE)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tail.active)
        begin
            out_status_reg <= tail.status;
            out_qty_reg    <= (tail.status == ST_DONE) ? tail.quantity : '0;
            out_slot_reg   <= (tail.status == ST_DONE) ? OSLOT_W'(tail.slot) : '0;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.quantity = out_qty_reg;
    assign rsp.slot     = out_slot_reg;

endmodule

`default_nettype wire

@@ src/kqt_cell.sv @@
`default_nettype none

module kqt_cell
    import kqt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic [SLOT_W-1:0] idx,
    input  wire logic [CNT_W-1:0]  fill,
    input  wire kqt_token_t        tok_in,
    output kqt_token_t             tok_out
);

    logic [KEY_W-1:0]        key_reg;
    logic signed [QTY_W-1:0] qty_reg;
    logic [KEY_W-1:0]        key_next;
    logic signed [QTY_W-1:0] qty_next;
    kqt_token_t              tok_reg;
    kqt_token_t              tok_next;

    logic                    open;
    logic                    filled;
    logic                    at_tail;
    logic                    hit;
    logic signed [QTY_W:0]   sum;
    logic signed [QTY_W-1:0] sat;

    always_comb
    begin
        open    = tok_in.active && (tok_in.status == ST_NOT_FOUND);
        filled  = CNT_W'(idx) < fill;
        at_tail = CNT_W'(idx) == fill;
        hit     = open && filled && (key_reg == tok_in.part_key);
        sum     = {qty_reg[QTY_W-1], qty_reg} + {tok_in.amount[QTY_W-1], tok_in.amount};
        if (sum[QTY_W] != sum[QTY_W-1])
        begin
            sat = sum[QTY_W] ? QTY_MIN : QTY_MAX;
        end
        else
        begin
            sat = sum[QTY_W-1:0];
        end

        tok_next = tok_in;
        key_next = key_reg;
        qty_next = qty_reg;
        if (hit && tok_in.action == ACT_INSERT)
        begin
            tok_next.status = ST_DUPLICATE;
        end
        else if (hit && tok_in.action == ACT_LOOKUP)
        begin
            tok_next.status   = ST_DONE;
            tok_next.quantity = qty_reg;
            tok_next.slot     = idx;
        end
        else if (hit && tok_in.action == ACT_UPDATE)
        begin
            tok_next.status   = ST_DONE;
            tok_next.quantity = sat;
            tok_next.slot     = idx;
            qty_next          = sat;
        end
        else if (open && at_tail && tok_in.action == ACT_INSERT)
        begin
            tok_next.status   = ST_DONE;
            tok_next.quantity = tok_in.amount;
            tok_next.slot     = idx;
            key_next          = tok_in.part_key;
            qty_next          = tok_in.amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg <= key_next;
            qty_reg <= qty_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
